/* design/fbpa_pkg.sv */
package fbpa_pkg;

  // Pool geometry, fixed by the 10-bit block index
  localparam int POOL_BLOCKS = 1024;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int BYTES_W     = 13;
  localparam int OFF_W       = 22;
  localparam int PROD_W      = IDX_W + BYTES_W;
  localparam int LINK_W      = IDX_W + 1;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_BYTES   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_USABLE_BLOCKS = 2'd1;

  localparam logic [BYTES_W-1:0] MIN_BLOCK_BYTES    = 13'd8;
  localparam logic [BYTES_W-1:0] RST_BLOCK_BYTES    = 13'd8;
  localparam logic [CNT_W-1:0]   RST_USABLE_BLOCKS  = 11'd1024;
  localparam logic [CNT_W-1:0]   POOL_LIMIT         = CNT_W'(POOL_BLOCKS);

  // Request opcodes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result status codes
  localparam logic STAT_DONE      = 1'b0;
  localparam logic STAT_EXHAUSTED = 1'b1;

endpackage

/* design/fbpa_ifs.sv */
interface fbpa_req_if
  import fbpa_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [IDX_W-1:0] block_index;

  modport source (output valid, output opcode, output block_index, input ready);
  modport sink   (input valid, input opcode, input block_index, output ready);
endinterface

interface fbpa_rsp_if
  import fbpa_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             status;
  logic [IDX_W-1:0] given_index;
  logic [OFF_W-1:0] byte_offset;

  modport source (output valid, output status, output given_index, output byte_offset,
                  input ready);
  modport sink   (input valid, input status, input given_index, input byte_offset,
                  output ready);
endinterface

interface fbpa_cfg_if
  import fbpa_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

/* design/fixed_block_pool_allocator_core.sv */
// Channel  Dir  Beat contents
// -------  ---  ------------------------------------------------
// req      in   opcode, block_index
// rsp      out  status, given_index, byte_offset
// cfg      in   addr (0 block_bytes, 1 usable_blocks), data
//
// For free, clear, carve and failed allocate the result beat is available the
// cycle after acceptance. An allocate that pops the free list first passes
// through S_POP, which waits on the registered read of the link memory.
// Reset (rst, synchronous) empties the list and zeroes the carve counter;
// the link memory needs no clearing pass. A two-entry result queue lets a
// new request be taken while one result beat is still stalled on rsp.
module fixed_block_pool_allocator_core
  import fbpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  fbpa_req_if.sink   req,
  fbpa_rsp_if.source rsp,
  fbpa_cfg_if.sink   cfg
);

  typedef enum logic {S_IDLE, S_POP} state_t;

  state_t             state;
  logic [BYTES_W-1:0] block_bytes;
  logic [CNT_W-1:0]   usable_blocks;
  logic [IDX_W-1:0]   free_top;
  logic               free_nonempty;
  logic [CNT_W-1:0]   carved_count;
  logic [IDX_W-1:0]   pop_index;

  // Link memory: {has_next, next index}
  logic [LINK_W-1:0]  link_mem [POOL_BLOCKS];
  logic [LINK_W-1:0]  link_rd;

  // Result queue
  logic               q_status [2];
  logic [IDX_W-1:0]   q_given  [2];
  logic [OFF_W-1:0]   q_off    [2];
  logic               q_wr_ptr;
  logic               q_rd_ptr;
  logic [1:0]         q_count;

  logic               accept;
  logic               rsp_take;
  logic               pop_start;
  logic               free_push;
  logic [BYTES_W-1:0] eff_bytes;
  logic [CNT_W-1:0]   eff_limit;
  logic               push;
  logic               push_status;
  logic [IDX_W-1:0]   push_given;
  logic [PROD_W-1:0]  push_prod;

  assign req.ready = (state == S_IDLE) && (q_count != 2'd2);
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;
  assign rsp_take  = rsp.valid && rsp.ready;
  assign pop_start = accept && (req.opcode == OP_ALLOC) && free_nonempty;
  assign free_push = accept && (req.opcode == OP_FREE);

  assign eff_bytes = (block_bytes < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : block_bytes;
  assign eff_limit = (usable_blocks > POOL_LIMIT) ? POOL_LIMIT : usable_blocks;

  // Result for this cycle
  always_comb begin
    push        = 1'b0;
    push_status = STAT_DONE;
    push_given  = '0;
    if (state == S_POP) begin
      push       = 1'b1;
      push_given = pop_index;
    end else if (accept) begin
      case (req.opcode)
        OP_ALLOC: begin
          if (!free_nonempty) begin
            push = 1'b1;
            if (carved_count < eff_limit) begin
              push_given = carved_count[IDX_W-1:0];
            end else begin
              push_status = STAT_EXHAUSTED;
            end
          end
        end
        default: begin
          push = 1'b1;
        end
      endcase
    end
  end

  assign push_prod = {{BYTES_W{1'b0}}, push_given} * {{IDX_W{1'b0}}, eff_bytes};

  // Link memory write on free, registered read on pop
  always_ff @(posedge clk) begin
    if (free_push) begin
      link_mem[req.block_index] <= {free_nonempty, free_top};
    end
    if (pop_start) begin
      link_rd <= link_mem[free_top];
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_status[q_wr_ptr] <= push_status;
      q_given[q_wr_ptr]  <= push_given;
      q_off[q_wr_ptr]    <= push_prod[OFF_W-1:0];
    end
  end

  assign rsp.valid       = (q_count != 2'd0);
  assign rsp.status      = q_status[q_rd_ptr];
  assign rsp.given_index = q_given[q_rd_ptr];
  assign rsp.byte_offset = q_off[q_rd_ptr];

  // Control state, list head, counters and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      block_bytes   <= RST_BLOCK_BYTES;
      usable_blocks <= RST_USABLE_BLOCKS;
      free_top      <= '0;
      free_nonempty <= 1'b0;
      carved_count  <= '0;
      pop_index     <= '0;
      q_wr_ptr      <= 1'b0;
      q_rd_ptr      <= 1'b0;
      q_count       <= 2'd0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.addr)
          REG_BLOCK_BYTES:   block_bytes   <= cfg.data[BYTES_W-1:0];
          REG_USABLE_BLOCKS: usable_blocks <= cfg.data[CNT_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.opcode)
              OP_ALLOC: begin
                if (free_nonempty) begin
                  pop_index <= free_top;
                  state     <= S_POP;
                end else if (carved_count < eff_limit) begin
                  carved_count <= carved_count + 1'b1;
                end
              end
              OP_FREE: begin
                free_top      <= req.block_index;
                free_nonempty <= 1'b1;
              end
              OP_CLEAR: begin
                free_top      <= '0;
                free_nonempty <= 1'b0;
                carved_count  <= '0;
              end
              default: ;
            endcase
          end
        end
        S_POP: begin
          free_top      <= link_rd[IDX_W-1:0];
          free_nonempty <= link_rd[IDX_W];
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (push) begin
        q_wr_ptr <= ~q_wr_ptr;
      end
      if (rsp_take) begin
        q_rd_ptr <= ~q_rd_ptr;
      end
      q_count <= q_count + {1'b0, push} - {1'b0, rsp_take};
    end
  end

endmodule
